// ===== hw/rtl/mpr_pkg.sv =====
// shared types and constants for the mouse picking ray block
`timescale 1ns / 1ps
`default_nettype none
package mpr_pkg;

   localparam int COORD_BITS = 12;
   localparam int NDC_W = 29;
   localparam int EYE_W = 36;
   localparam int PROD_W = 52;
   localparam int ACC_W = 56;
   localparam int MAG_W = 55;
   localparam int DVD_W = 45;
   localparam int DVS_W = 31;
   localparam int QUO_W = 27;
   localparam logic [4:0] DIV_LONG_STEPS = 5'd27;
   localparam logic [4:0] DIV_SHORT_STEPS = 5'd15;
   localparam int VIEW_DEPTH = 9;

   typedef enum logic [3:0] {
      CSR_WIDTH   = 4'd0,
      CSR_HEIGHT  = 4'd1,
      CSR_PROJ_XX = 4'd2,
      CSR_PROJ_XY = 4'd3,
      CSR_PROJ_XO = 4'd4,
      CSR_PROJ_YX = 4'd5,
      CSR_PROJ_YY = 4'd6,
      CSR_PROJ_YO = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic                    mode;
      logic [COORD_BITS-1:0]   mouse_x;
      logic [COORD_BITS-1:0]   mouse_y;
      logic [3:0]              entry_index;
      logic signed [15:0]      entry_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] ray_x;
      logic signed [15:0] ray_y;
      logic signed [15:0] ray_z;
      logic               zero_length;
   } rsp_type;

   typedef struct packed {
      logic                  is_pick;
      logic                  load_ok;
      logic [3:0]            idx;
      logic signed [15:0]    value;
      logic [COORD_BITS-1:0] mouse_x;
      logic [COORD_BITS-1:0] mouse_y;
   } item_type;

   typedef struct packed {
      logic [12:0]        width;
      logic [12:0]        height;
      logic signed [15:0] proj_xx;
      logic signed [15:0] proj_xy;
      logic signed [15:0] proj_xo;
      logic signed [15:0] proj_yx;
      logic signed [15:0] proj_yy;
      logic signed [15:0] proj_yo;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic             long_op;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mpr_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module mpr_front import mpr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          full,
   input  wire req_type  req_data,
   output logic          item_valid,
   output item_type      item,
   input  wire logic     item_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   item_type   cls;

   always_comb begin
      cls.is_pick = req_data.mode;
      cls.load_ok = (req_data.entry_index < 4'(VIEW_DEPTH));
      cls.idx     = req_data.entry_index;
      cls.value   = req_data.entry_value;
      cls.mouse_x = req_data.mouse_x;
      cls.mouse_y = req_data.mouse_y;
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/mpr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mpr_div import mpr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvs_in  = req.divisor;
         quo_in  = '0;
         busy_in = 1'b1;
         if (req.long_op) begin
            rem_in = DVS_W'(req.dividend >> DIV_LONG_STEPS);
            dvd_in = req.dividend << (DVD_W - 27);
            cnt_in = DIV_LONG_STEPS;
         end else begin
            rem_in = DVS_W'(req.dividend >> DIV_SHORT_STEPS);
            dvd_in = req.dividend << (DVD_W - 15);
            cnt_in = DIV_SHORT_STEPS;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mpr_back.sv =====
// back end: sequencer that computes the picking ray and holds the result slot
`timescale 1ns / 1ps
`default_nettype none
module mpr_back import mpr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     item_valid,
   input  wire item_type item,
   output logic          item_pop,
   output logic          empty,
   output rsp_type       rsp_data,
   input  wire logic     pop
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_NDCX = 13'b0000000000010,
      ST_NDCY = 13'b0000000000100,
      ST_MUL  = 13'b0000000001000,
      ST_ACC  = 13'b0000000010000,
      ST_PREP = 13'b0000000100000,
      ST_NORM = 13'b0000001000000,
      ST_RSH  = 13'b0000010000000,
      ST_LSH  = 13'b0000100000000,
      ST_SQ   = 13'b0001000000000,
      ST_SUM  = 13'b0010000000000,
      ST_SQRT = 13'b0100000000000,
      ST_DIV  = 13'b1000000000000
   } state_type;

   localparam logic [MAG_W-1:0] MAX_HI = MAG_W'(64'd1 << 30);
   localparam logic [MAG_W-1:0] MAX_DBL = MAG_W'(64'd1 << 31);
   localparam logic [MAG_W-1:0] MAX_LO = MAG_W'(64'd1 << 29);

   state_type state_ff, state_in;
   logic signed [15:0]      view_ff [VIEW_DEPTH];
   logic [COORD_BITS-1:0]   my_ff;
   logic signed [NDC_W-1:0] nx_ff, ny_ff;
   logic signed [EYE_W-1:0] eye0_ff, eye1_ff;
   logic signed [ACC_W-1:0] world_ff [3];
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [MAG_W-1:0]        m_ff [3];
   logic [MAG_W-1:0]        max_ff;
   logic [61:0]             sq_ff;
   logic [61:0]             sum_ff;
   logic [62:0]             sqs_ff, sqr_ff, bit_ff;
   logic [2:0]              dot_ff;
   logic [1:0]              k_ff;
   logic                    div_wait_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, res_ff;
   logic                    res_valid_ff;

   logic [12:0]             wdiv, hdiv;
   div_req_type             dreq;
   logic                    div_done;
   logic [QUO_W-1:0]        div_q;
   logic signed [15:0]      a_sel;
   logic signed [EYE_W-1:0] b_sel;
   logic signed [ACC_W-1:0] acc_sum;
   logic [ACC_W-1:0]        acc_mag, rd_mag;
   logic signed [EYE_W-1:0] eye_r;
   logic [MAG_W-1:0]        mg [3];
   logic [MAG_W-1:0]        mx;
   logic [62:0]             sq_t;
   logic [DVS_W-1:0]        len;
   logic [15:0]             qv;

   mpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (dreq),
      .done     (div_done),
      .quotient (div_q)
   );

   assign wdiv = (cfg.width == 13'd0) ? 13'd1 : cfg.width;
   assign hdiv = (cfg.height == 13'd0) ? 13'd1 : cfg.height;
   assign len  = sqr_ff[DVS_W-1:0];
   assign sq_t = sqr_ff + bit_ff;
   assign qv   = div_q[15:0];

   always_comb begin
      a_sel = '0;
      b_sel = '0;
      unique case (dot_ff)
         3'd0: begin
            case (k_ff)
               2'd0: a_sel = cfg.proj_xx;
               2'd1: a_sel = cfg.proj_xy;
               default: a_sel = cfg.proj_xo;
            endcase
         end
         3'd1: begin
            case (k_ff)
               2'd0: a_sel = cfg.proj_yx;
               2'd1: a_sel = cfg.proj_yy;
               default: a_sel = cfg.proj_yo;
            endcase
         end
         3'd2: a_sel = view_ff[4'(k_ff)];
         3'd3: a_sel = view_ff[4'd3 + 4'(k_ff)];
         3'd4: a_sel = view_ff[4'd6 + 4'(k_ff)];
         default: a_sel = '0;
      endcase
      if (dot_ff < 3'd2) begin
         case (k_ff)
            2'd0: b_sel = EYE_W'(nx_ff);
            2'd1: b_sel = EYE_W'(ny_ff);
            default: b_sel = EYE_W'(16384);
         endcase
      end else begin
         case (k_ff)
            2'd0: b_sel = eye0_ff;
            2'd1: b_sel = eye1_ff;
            default: b_sel = -EYE_W'(16384);
         endcase
      end
   end

   always_comb begin
      acc_sum = ((k_ff == 2'd0) ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
      acc_mag = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
      rd_mag  = (acc_mag + ACC_W'(2048)) >> 12;
      eye_r   = acc_sum[ACC_W-1] ? -EYE_W'(rd_mag) : EYE_W'(rd_mag);
      for (int i = 0; i < 3; i++) begin
         mg[i] = world_ff[i][ACC_W-1] ? MAG_W'(-world_ff[i]) : MAG_W'(world_ff[i]);
      end
      mx = mg[0];
      if (mg[1] > mx) mx = mg[1];
      if (mg[2] > mx) mx = mg[2];
   end

   always_comb begin
      state_in       = state_ff;
      item_pop       = 1'b0;
      dreq.start     = 1'b0;
      dreq.long_op   = 1'b1;
      dreq.dividend  = '0;
      dreq.divisor   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && !res_valid_ff) begin
               item_pop = 1'b1;
               if (item.is_pick) begin
                  dreq.start    = 1'b1;
                  dreq.dividend = DVD_W'({item.mouse_x, 15'd0}) + DVD_W'(wdiv >> 1);
                  dreq.divisor  = DVS_W'(wdiv);
                  state_in      = ST_NDCX;
               end
            end
         end
         ST_NDCX: begin
            if (div_done) begin
               dreq.start    = 1'b1;
               dreq.dividend = DVD_W'({my_ff, 15'd0}) + DVD_W'(hdiv >> 1);
               dreq.divisor  = DVS_W'(hdiv);
               state_in      = ST_NDCY;
            end
         end
         ST_NDCY: if (div_done) state_in = ST_MUL;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (k_ff == 2'd2 && dot_ff == 3'd4) state_in = ST_PREP;
            else state_in = ST_MUL;
         end
         ST_PREP: state_in = ST_NORM;
         ST_NORM: begin
            if (max_ff == '0) state_in = ST_IDLE;
            else if (max_ff > MAX_HI) state_in = ST_RSH;
            else state_in = ST_LSH;
         end
         ST_RSH: if (max_ff < MAX_DBL) state_in = ST_SQ;
         ST_LSH: if (max_ff >= MAX_LO) state_in = ST_SQ;
         ST_SQ: state_in = ST_SUM;
         ST_SUM: state_in = (k_ff == 2'd2) ? ST_SQRT : ST_SQ;
         ST_SQRT: if (bit_ff == 63'd1) state_in = ST_DIV;
         ST_DIV: begin
            if (!div_wait_ff) begin
               dreq.start    = 1'b1;
               dreq.long_op  = 1'b0;
               dreq.dividend = DVD_W'({m_ff[k_ff][30:0], 14'd0}) + DVD_W'(len >> 1);
               dreq.divisor  = len;
            end else if (div_done && k_ff == 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         div_wait_ff  <= 1'b0;
         for (int i = 0; i < VIEW_DEPTH; i++) begin
            view_ff[i] <= ((i % 4) == 0) ? 16'sd4096 : 16'sd0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && item_valid && !res_valid_ff && !item.is_pick
             && item.load_ok) begin
            view_ff[item.idx] <= item.value;
         end
         if (state_ff == ST_NORM && max_ff == '0) begin
            res_valid_ff <= 1'b1;
         end else if (state_ff == ST_DIV && div_wait_ff && div_done && k_ff == 2'd2) begin
            res_valid_ff <= 1'b1;
         end else if (res_valid_ff && !rsp_valid_ff) begin
            res_valid_ff <= 1'b0;
         end
         if (res_valid_ff && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DIV) begin
            div_wait_ff <= !div_wait_ff ? 1'b1 : !div_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid_ff && !rsp_valid_ff) rsp_ff <= res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            my_ff  <= item.mouse_y;
            dot_ff <= 3'd0;
            k_ff   <= 2'd0;
         end
         ST_NDCX: if (div_done) nx_ff <= $signed({2'b00, div_q}) - NDC_W'(16384);
         ST_NDCY: if (div_done) ny_ff <= NDC_W'(16384) - $signed({2'b00, div_q});
         ST_MUL: prod_ff <= PROD_W'(a_sel) * PROD_W'(b_sel);
         ST_ACC: begin
            acc_ff <= acc_sum;
            if (k_ff == 2'd2) begin
               k_ff <= 2'd0;
               dot_ff <= dot_ff + 3'd1;
               case (dot_ff)
                  3'd0: eye0_ff <= eye_r;
                  3'd1: eye1_ff <= eye_r;
                  3'd2: world_ff[0] <= acc_sum;
                  3'd3: world_ff[1] <= acc_sum;
                  default: world_ff[2] <= acc_sum;
               endcase
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         ST_PREP: begin
            for (int i = 0; i < 3; i++) m_ff[i] <= mg[i];
            max_ff <= mx;
            res_ff.ray_x       <= '0;
            res_ff.ray_y       <= '0;
            res_ff.ray_z       <= '0;
            res_ff.zero_length <= 1'b1;
         end
         ST_NORM: k_ff <= 2'd0;
         ST_RSH: begin
            if (max_ff >= MAX_DBL) begin
               max_ff <= max_ff >> 1;
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
            end else begin
               max_ff <= (max_ff + MAG_W'(1)) >> 1;
               for (int i = 0; i < 3; i++) m_ff[i] <= (m_ff[i] + MAG_W'(1)) >> 1;
            end
         end
         ST_LSH: begin
            if (max_ff < MAX_LO) begin
               max_ff <= max_ff << 1;
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end
         end
         ST_SQ: sq_ff <= m_ff[k_ff][30:0] * m_ff[k_ff][30:0];
         ST_SUM: begin
            sum_ff <= ((k_ff == 2'd0) ? 62'd0 : sum_ff) + sq_ff;
            if (k_ff == 2'd2) begin
               k_ff   <= 2'd0;
               sqs_ff <= 63'(((k_ff == 2'd0) ? 62'd0 : sum_ff) + sq_ff);
               sqr_ff <= '0;
               bit_ff <= 63'd1 << 62;
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (sqs_ff >= sq_t) begin
               sqs_ff <= sqs_ff - sq_t;
               sqr_ff <= (sqr_ff >> 1) + bit_ff;
            end else begin
               sqr_ff <= sqr_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            res_ff.zero_length <= 1'b0;
         end
         ST_DIV: begin
            if (div_wait_ff && div_done) begin
               case (k_ff)
                  2'd0: res_ff.ray_x <= world_ff[0][ACC_W-1] ? -$signed(qv) : $signed(qv);
                  2'd1: res_ff.ray_y <= world_ff[1][ACC_W-1] ? -$signed(qv) : $signed(qv);
                  default: res_ff.ray_z <= world_ff[2][ACC_W-1] ? -$signed(qv) : $signed(qv);
               endcase
               k_ff <= k_ff + 2'd1;
            end
         end
         default: k_ff <= k_ff;
      endcase
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_zero_rays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_length |->
         rsp_ff.ray_x == 16'sd0 && rsp_ff.ray_y == 16'sd0 && rsp_ff.ray_z == 16'sd0)
      else $error("zero length result with nonzero ray");
   a_ray_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.ray_x >= -16'sd16384 && rsp_ff.ray_x <= 16'sd16384
         && rsp_ff.ray_y >= -16'sd16384 && rsp_ff.ray_y <= 16'sd16384
         && rsp_ff.ray_z >= -16'sd16384 && rsp_ff.ray_z <= 16'sd16384)
      else $error("ray component out of unit range");
   a_norm_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ |-> max_ff >= MAX_LO && max_ff <= MAX_HI)
      else $error("normalized magnitude out of window");
   a_len_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT && bit_ff == 63'd1 |=> sqr_ff >= 63'(MAX_LO))
      else $error("vector length below normalized floor");

endmodule
`default_nettype wire

// ===== hw/rtl/mouse_pick_ray_top.sv =====
// top level of the mouse picking ray block: register file, front and back ends
// a pick runs two divides for the window mapping, 15 multiply-accumulate steps,
// normalize shifts, a 32-step square root and three divides, all on one divider;
// a zero ray ends at the normalize step with no square root and no divides
// one item in the back end at a time; the front queue holds two items
// synchronous active-high reset restores the identity view and default registers
`timescale 1ns / 1ps
`default_nettype none
module mouse_pick_ray_top import mpr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     item_valid;
   item_type item;
   logic     item_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:   cfg_in.width   = csr_data[12:0];
            CSR_HEIGHT:  cfg_in.height  = csr_data[12:0];
            CSR_PROJ_XX: cfg_in.proj_xx = csr_data;
            CSR_PROJ_XY: cfg_in.proj_xy = csr_data;
            CSR_PROJ_XO: cfg_in.proj_xo = csr_data;
            CSR_PROJ_YX: cfg_in.proj_yx = csr_data;
            CSR_PROJ_YY: cfg_in.proj_yy = csr_data;
            CSR_PROJ_YO: cfg_in.proj_yo = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width   <= 13'd1024;
         cfg_ff.height  <= 13'd768;
         cfg_ff.proj_xx <= 16'sd4096;
         cfg_ff.proj_xy <= 16'sd0;
         cfg_ff.proj_xo <= 16'sd0;
         cfg_ff.proj_yx <= 16'sd0;
         cfg_ff.proj_yy <= 16'sd4096;
         cfg_ff.proj_yo <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   mpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .empty      (empty),
      .rsp_data   (rsp_data),
      .pop        (pop)
   );

endmodule
`default_nettype wire
